// ----- rtl/ssu_pkg.sv -----
package ssu_pkg;

  localparam int RANGE_BITS = 16;
  localparam int ROT_ITERS = 16;
  localparam int NORM_FRAC = 30 - RANGE_BITS;
  localparam int CW = RANGE_BITS + 1;
  localparam int RW = RANGE_BITS + 12;
  localparam int ZW = 24;
  localparam int SW = 2 * CW + 1;
  localparam int QW = 2 * SW + 2 * NORM_FRAC;
  localparam int MW = CW + 15 + NORM_FRAC;
  localparam int IW = $clog2(ROT_ITERS + 1);
  localparam int KW = 6;

  localparam logic [1:0] CFG_ANGLE_STEP = 2'd0;
  localparam logic [1:0] CFG_GAIN = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROT, ST_COMP, ST_SUM, ST_SQRT, ST_DIVX, ST_DIVY, ST_DOT, ST_GAIN,
    ST_OUT1, ST_OUT2
  } state_t;

  typedef struct packed {
    logic load;
    logic rot_step;
    logic comp;
    logic sum;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_sel_y;
    logic div_step;
    logic unit_y;
    logic dot;
    logic gain_mul;
    logic commit;
  } ssu_cmd_t;

  typedef struct packed {
    logic rot_done;
    logic sqrt_done;
    logic div_done;
    logic seg_zero;
  } ssu_sts_t;

  function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
    logic [ZW-1:0] r;
    case (i)
      5'd0: r = 24'd2097152;  5'd1: r = 24'd1238021; 5'd2: r = 24'd654136;
      5'd3: r = 24'd332050;   5'd4: r = 24'd166669;  5'd5: r = 24'd83416;
      5'd6: r = 24'd41718;    5'd7: r = 24'd20860;   5'd8: r = 24'd10430;
      5'd9: r = 24'd5215;     5'd10: r = 24'd2608;   5'd11: r = 24'd1304;
      5'd12: r = 24'd652;     5'd13: r = 24'd326;    5'd14: r = 24'd163;
      5'd15: r = 24'd81;      5'd16: r = 24'd41;     5'd17: r = 24'd20;
      5'd18: r = 24'd10;      5'd19: r = 24'd5;      5'd20: r = 24'd3;
      5'd21: r = 24'd1;       5'd22: r = 24'd1;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/ssu_ctrl.sv -----
module ssu_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic last,
  input  logic [1:0] seen,
  input  logic out_ready,
  input  ssu_pkg::ssu_sts_t sts,
  output ssu_pkg::ssu_cmd_t cmd,
  output logic in_ready,
  output logic out_valid,
  output logic out_second
);
  import ssu_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    out_second = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = ST_ROT;
        end
      end
      ST_ROT: begin
        if (sts.rot_done) begin
          state_next = ST_COMP;
        end else begin
          cmd.rot_step = 1'b1;
        end
      end
      ST_COMP: begin
        cmd.comp = 1'b1;
        state_next = (seen == 2'd0) ? ST_OUT2 : ST_SUM;
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        if (sts.seg_zero) begin
          state_next = ST_DOT;
        end else begin
          cmd.sqrt_init = 1'b1;
          state_next = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (!sts.sqrt_done) begin
          cmd.sqrt_step = 1'b1;
        end else if (sts.div_done) begin
          cmd.div_init = 1'b1;
          cmd.div_sel_y = 1'b1;
          state_next = ST_DIVY;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_DIVY: begin
        if (sts.div_done) begin
          cmd.unit_y = 1'b1;
          state_next = ST_DOT;
        end else begin
          cmd.div_step = 1'b1;
          cmd.div_sel_y = 1'b1;
        end
      end
      ST_DOT: begin
        cmd.dot = 1'b1;
        state_next = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.gain_mul = 1'b1;
        state_next = (seen == 2'd2) ? ST_OUT1 : (last ? ST_OUT2 : ST_IDLE);
        if (seen != 2'd2 && !last) begin
          cmd.commit = 1'b1;
        end
      end
      ST_OUT1: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (last) begin
            state_next = ST_OUT2;
          end else begin
            cmd.commit = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_OUT2: begin
        out_valid = 1'b1;
        out_second = 1'b1;
        if (out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/ssu_dp.sv -----
module ssu_dp (
  input  logic clk,
  input  logic rst,
  input  ssu_pkg::ssu_cmd_t cmd,
  input  logic [15:0] range_mm,
  input  logic end_of_scan,
  input  logic cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [23:0] cfg_data,
  input  logic out_second,
  output ssu_pkg::ssu_sts_t sts,
  output logic last,
  output logic [1:0] seen,
  output logic [19:0] unflatness,
  output logic scan_done
);
  import ssu_pkg::*;

  logic [23:0] angle_step, angle_acc;
  logic [15:0] gain;
  logic signed [CW-1:0] prev_x, prev_y, cur_x, cur_y;
  logic signed [15:0] prev_ux, prev_uy, ux, uy;
  logic signed [RW-1:0] rx, ry;
  logic signed [ZW:0] rz;
  logic [1:0] quad;
  logic [IW-1:0] it;
  logic signed [CW:0] dx, dy;
  logic [QW-1:0] sq_v, sq_r, sq_bit;
  logic [MW-1:0] dv_num, dv_quo;
  logic [KW-1:0] dv_cnt;
  logic dv_neg;
  logic signed [32:0] one_minus;
  logic [19:0] res;

  logic signed [RW-1:0] sx, sy;
  logic signed [RW+16:0] mx, my;
  logic signed [RW:0] ccx, ccy, fx, fy;
  logic signed [ZW-1:0] atv;
  logic signed [CW:0] ddx, ddy;
  logic signed [2*CW+1:0] pdx, pdy;
  logic [SW-1:0] ssum;
  logic [QW-1:0] sq_try;
  logic [MW:0] dv_rem;
  logic [MW-1:0] babs;
  logic signed [31:0] pxx, pyy;
  logic signed [33:0] om_c;
  logic [49:0] gprod;
  logic [36:0] grnd;

  // rounded quotient with saturation, remainder compare for the half step
  function automatic logic [15:0] uq_sat(input logic [MW-1:0] q, input logic [MW-1:0] r,
                                         input logic [QW-1:0] n);
    logic [MW+1:0] r2;
    logic [MW:0] qr;
    r2 = {r, 1'b0};
    qr = {1'b0, q} + ((r2 >= (MW+2)'(n)) ? (MW+1)'(1) : (MW+1)'(0));
    return (qr > (MW+1)'(32767)) ? 16'd32767 : 16'(qr);
  endfunction

  always_comb begin
    sx = rx >>> it;
    sy = ry >>> it;
    atv = ZW'(atan_lut(5'(it)));
    mx = RW'(rx) * $signed(17'sd39797) + (RW+17)'(1 <<< 23);
    my = RW'(ry) * $signed(17'sd39797) + (RW+17)'(1 <<< 23);
    ccx = (RW+1)'(mx >>> 24);
    ccy = (RW+1)'(my >>> 24);
    case (quad)
      2'd1: begin fx = -ccy; fy = ccx; end
      2'd2: begin fx = -ccx; fy = -ccy; end
      2'd3: begin fx = ccy; fy = -ccx; end
      default: begin fx = ccx; fy = ccy; end
    endcase
    ddx = (CW+1)'(cur_x) - (CW+1)'(prev_x);
    ddy = (CW+1)'(cur_y) - (CW+1)'(prev_y);
    pdx = ddx * ddx;
    pdy = ddy * ddy;
    ssum = SW'(pdx + pdy);
    sq_try = sq_r + sq_bit;
    babs = cmd.div_sel_y ? MW'(dy < 0 ? -dy : dy) : MW'(dx < 0 ? -dx : dx);
    dv_rem = {dv_num, dv_quo[MW-1]};
    pxx = prev_ux * ux;
    pyy = prev_uy * uy;
    om_c = 34'sd1073741824 - (34'(pxx) + 34'(pyy));
    gprod = 50'(one_minus) * gain;
    grnd = 37'((gprod + 50'(1 << 27)) >> 28);
  end

  assign sts.rot_done = (it == IW'(ROT_ITERS));
  assign sts.sqrt_done = (sq_bit == '0);
  assign sts.div_done = (dv_cnt == '0);
  assign sts.seg_zero = (sq_v == '0);
  assign unflatness = out_second ? 20'd0 : res;
  assign scan_done = out_second && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_step <= 24'd11651;
      gain <= 16'd4096;
      angle_acc <= '0;
      seen <= '0;
      prev_x <= '0;
      prev_y <= '0;
      prev_ux <= '0;
      prev_uy <= '0;
      it <= '0;
    end else begin
      if (cfg_we && cfg_idx == CFG_ANGLE_STEP) angle_step <= cfg_data;
      if (cfg_we && cfg_idx == CFG_GAIN) gain <= cfg_data[15:0];
      if (cmd.load) begin
        rx <= RW'({range_mm[RANGE_BITS-1:0], 8'd0});
        ry <= '0;
        rz <= (ZW+1)'(angle_acc[21:0]);
        quad <= angle_acc[23:22];
        last <= end_of_scan;
        it <= '0;
        ux <= '0;
        uy <= '0;
        res <= '0;
        angle_acc <= angle_acc + angle_step;
      end
      if (cmd.rot_step) begin
        if (!rz[ZW]) begin
          rx <= rx - sy; ry <= ry + sx; rz <= rz - (ZW+1)'(atv);
        end else begin
          rx <= rx + sy; ry <= ry - sx; rz <= rz + (ZW+1)'(atv);
        end
        it <= it + 1'b1;
      end
      if (cmd.comp) begin
        cur_x <= (fx < -(RW+1)'(1 <<< RANGE_BITS)) ? -CW'(1 <<< RANGE_BITS) :
                 (fx > (RW+1)'((1 <<< RANGE_BITS) - 1)) ? CW'((1 <<< RANGE_BITS) - 1) :
                 CW'(fx);
        cur_y <= (fy < -(RW+1)'(1 <<< RANGE_BITS)) ? -CW'(1 <<< RANGE_BITS) :
                 (fy > (RW+1)'((1 <<< RANGE_BITS) - 1)) ? CW'((1 <<< RANGE_BITS) - 1) :
                 CW'(fy);
      end
      if (cmd.sum) begin
        dx <= ddx;
        dy <= ddy;
        sq_v <= QW'(ssum);
      end
      if (cmd.sqrt_init) begin
        sq_v <= sq_v << (2 * NORM_FRAC);
        sq_r <= '0;
        sq_bit <= QW'(1) << (QW - 2);
        dv_cnt <= '0;
      end
      if (cmd.sqrt_step) begin
        if (sq_v >= sq_try) begin
          sq_v <= sq_v - sq_try;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
        if (sq_bit == QW'(1)) begin
          dv_num <= '0;
          dv_quo <= MW'(dx < 0 ? -dx : dx) << (15 + NORM_FRAC);
          dv_neg <= dx < 0;
          dv_cnt <= KW'(MW);
        end
      end
      if (cmd.div_init) begin
        dv_num <= '0;
        dv_quo <= babs << (15 + NORM_FRAC);
        dv_neg <= dy < 0;
        dv_cnt <= KW'(MW);
        ux <= 16'(dv_neg ? -$signed(17'(uq_sat(dv_quo, dv_num, sq_r)))
                         : $signed(17'(uq_sat(dv_quo, dv_num, sq_r))));
      end
      if (cmd.div_step) begin
        if ({1'b0, dv_num, dv_quo[MW-1]} >= {1'b0, sq_r[MW:0]}) begin
          dv_num <= MW'(dv_rem - MW'(sq_r));
          dv_quo <= {dv_quo[MW-2:0], 1'b1};
        end else begin
          dv_num <= MW'(dv_rem);
          dv_quo <= {dv_quo[MW-2:0], 1'b0};
        end
        dv_cnt <= dv_cnt - 1'b1;
      end
      if (cmd.unit_y) begin
        uy <= 16'(dv_neg ? -$signed(17'(uq_sat(dv_quo, dv_num, sq_r)))
                         : $signed(17'(uq_sat(dv_quo, dv_num, sq_r))));
      end
      if (cmd.dot) begin
        one_minus <= (om_c < 0) ? 33'sd0 : 33'(om_c);
      end
      if (cmd.gain_mul) begin
        res <= (grnd > 37'd1048575) ? 20'hFFFFF : 20'(grnd);
      end
      if (cmd.commit) begin
        prev_x <= cur_x;
        prev_y <= cur_y;
        if (seen != 2'd0) begin
          prev_ux <= ux;
          prev_uy <= uy;
        end
        if (last) begin
          seen <= '0;
          angle_acc <= '0;
        end else if (seen != 2'd2) begin
          seen <= seen + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/scan_segment_unflatness.sv -----
// channel | signals                                  | transfer when
// in      | in_valid in_ready range_mm end_of_scan   | in_valid && in_ready
// out     | out_valid out_ready unflatness scan_done | out_valid && out_ready
// cfg     | cfg_we cfg_idx cfg_data                  | cfg_we
// an inner sample offers its result after the 16-step cordic rotator, the
// 49-step square root, the x division, the y division and the remaining steps;
// a first sample of a scan offers its result after the rotator and the clamp,
// a zero-length segment skips the square root and both divisions; input is
// taken again only once every result has been taken
// output stalls freeze the sequencer; rst is synchronous and restores register
// defaults and the scan state
module scan_segment_unflatness (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [15:0] range_mm,
  input  logic end_of_scan,
  output logic out_valid,
  input  logic out_ready,
  output logic [19:0] unflatness,
  output logic scan_done,
  input  logic cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [23:0] cfg_data
);
  import ssu_pkg::*;

  ssu_cmd_t cmd;
  ssu_sts_t sts;
  logic last, out_second;
  logic [1:0] seen;

  ssu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_valid && in_ready), .last(last), .seen(seen),
    .out_ready(out_ready), .sts(sts), .cmd(cmd), .in_ready(in_ready),
    .out_valid(out_valid), .out_second(out_second)
  );

  ssu_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .range_mm(range_mm), .end_of_scan(end_of_scan),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data), .out_second(out_second),
    .sts(sts), .last(last), .seen(seen), .unflatness(unflatness), .scan_done(scan_done)
  );

endmodule

// ----- test/scan_segment_unflatness_tb.sv -----
`timescale 1ns / 100ps

module scan_segment_unflatness_tb;
  import ssu_pkg::*;

  typedef struct {
    logic [19:0] unflatness;
    logic scan_done;
  } result_t;

  typedef struct {
    logic [15:0] range_mm;
    logic end_of_scan;
    bit typed;
    logic [19:0] unflatness;
    logic scan_done;
  } row_t;

  logic clk, rst;
  logic in_valid, in_ready;
  logic [15:0] range_mm;
  logic end_of_scan;
  logic out_valid, out_ready;
  logic [19:0] unflatness;
  logic scan_done;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [23:0] cfg_data;

  scan_segment_unflatness u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .range_mm(range_mm),
    .end_of_scan(end_of_scan),
    .out_valid(out_valid), .out_ready(out_ready), .unflatness(unflatness),
    .scan_done(scan_done),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // scan tracker state
  logic [23:0] step_q;
  logic [15:0] gain_q;
  int unsigned seen_cnt;
  logic [23:0] angle_q;
  longint px, py, pux, puy;

  result_t expected_q[$];
  int mismatches = 0;
  longint cycles = 0;
  int send_idle_pct, stall_pct;
  bit hold_start, hold_on;

  longint atan_steps[24] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void queue_result(input result_t e);
    expected_q = {expected_q, e};
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unit_part(longint d, longint unsigned n);
    longint unsigned m;
    longint q;
    m = longint'(d < 0 ? -d : d) << (15 + NORM_FRAC);
    q = longint'((m + n / 2) / n);
    if (q > 32767) q = 32767;
    return d < 0 ? -q : q;
  endfunction

  task automatic polar_to_xy(input logic [15:0] r, input logic [23:0] ang,
                             output longint ox, output longint oy);
    longint x, y, z, dx, dy, cx, cy, t, lim;
    x = longint'(r) * 256;
    y = 0;
    z = longint'(ang[21:0]);
    lim = longint'(1) << RANGE_BITS;
    for (int i = 0; i < ROT_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_steps[i];
      end else begin
        x += dx; y -= dy; z += atan_steps[i];
      end
    end
    cx = (x * 39797 + (longint'(1) << 23)) >>> 24;
    cy = (y * 39797 + (longint'(1) << 23)) >>> 24;
    case (ang[23:22])
      2'd1: begin t = cx; cx = -cy; cy = t; end
      2'd2: begin cx = -cx; cy = -cy; end
      2'd3: begin t = cx; cx = cy; cy = -t; end
      default: ;
    endcase
    ox = clamp(cx, -lim, lim - 1);
    oy = clamp(cy, -lim, lim - 1);
  endtask

  task automatic track_sample(input logic [15:0] r, input logic eos);
    longint x, y, dx, dy, ux, uy, om, g;
    longint unsigned s, n;
    result_t res;
    polar_to_xy(r, angle_q, x, y);
    angle_q = angle_q + step_q;
    if (seen_cnt == 0) begin
      res.unflatness = 0; res.scan_done = eos;
      queue_result(res);
    end else begin
      dx = x - px; dy = y - py; ux = 0; uy = 0;
      s = longint'(dx * dx + dy * dy);
      if (s != 0) begin
        n = int_sqrt(s << (2 * NORM_FRAC));
        ux = unit_part(dx, n);
        uy = unit_part(dy, n);
      end
      if (seen_cnt >= 2) begin
        om = (longint'(1) << 30) - (pux * ux + puy * uy);
        if (om < 0) om = 0;
        g = (om * longint'(gain_q) + (longint'(1) << 27)) >>> 28;
        res.unflatness = 20'(clamp(g, 0, 1048575));
        res.scan_done = 0;
        queue_result(res);
      end
      if (eos) begin
        res.unflatness = 0; res.scan_done = 1;
        queue_result(res);
      end
      pux = ux; puy = uy;
    end
    px = x; py = y;
    if (seen_cnt < 2) seen_cnt++;
    if (eos) begin
      seen_cnt = 0;
      angle_q = 0;
    end
  endtask

  task automatic send(input logic [15:0] r, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    range_mm <= r;
    end_of_scan <= eos;
    do @(posedge clk); while (!in_ready);
    track_sample(r, eos);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    in_valid <= 0;
    wait (expected_q.size() == 0);
    repeat (120) @(posedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_ANGLE_STEP) step_q = val;
    else if (idx == CFG_GAIN) gain_q = val[15:0];
  endtask

  task automatic random_scans(input int count);
    int n, len, style;
    logic [15:0] base, r;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
      style = $urandom_range(3);
      base = 16'($urandom);
      for (int k = 0; k < len; k++) begin
        case (style)
          0: r = 16'($urandom);
          1: r = base + 16'($urandom_range(0, 40)) - 16'd20;
          2: r = 16'($urandom_range(0, 15));
          default: r = base;
        endcase
        send(r, k == len - 1);
        n++;
      end
    end
  endtask

  // long receiver hold, counted here
  initial begin
    hold_on = 0;
    wait (hold_start);
    hold_on <= 1;
    repeat (3000) @(posedge clk);
    hold_on <= 0;
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else if (hold_on) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: unflatness=%0d scan_done=%0d", unflatness, scan_done);
      end else begin
        e = expected_q.pop_front();
        if (unflatness !== e.unflatness || scan_done !== e.scan_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected unflatness=%0d scan_done=%0d, got %0d %0d",
                     e.unflatness, e.scan_done, unflatness, scan_done);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("scan_segment_unflatness_tb: FAIL");
      $finish;
    end
  end

  row_t rows[] = '{
    '{16'd0, 1'b1, 1, 20'd0, 1'b1},
    '{16'd65535, 1'b1, 1, 20'd0, 1'b1},
    '{16'd100, 1'b0, 1, 20'd0, 1'b0},
    '{16'd100, 1'b1, 1, 20'd0, 1'b1},
    '{16'd0, 1'b0, 1, 20'd0, 1'b0},
    '{16'd65535, 1'b0, 0, 0, 0},
    '{16'd0, 1'b0, 0, 0, 0},
    '{16'd65535, 1'b0, 0, 0, 0},
    '{16'd1, 1'b1, 0, 0, 0},
    '{16'd0, 1'b0, 0, 0, 0},
    '{16'd0, 1'b0, 0, 0, 0},
    '{16'd0, 1'b0, 0, 0, 0},
    '{16'd0, 1'b1, 0, 0, 0},
    '{16'd1000, 1'b0, 0, 0, 0},
    '{16'd1000, 1'b0, 0, 0, 0},
    '{16'd1000, 1'b0, 0, 0, 0},
    '{16'd1000, 1'b0, 0, 0, 0},
    '{16'd43690, 1'b0, 0, 0, 0},
    '{16'd21845, 1'b0, 0, 0, 0},
    '{16'd1000, 1'b1, 0, 0, 0}
  };

  initial begin
    rst = 1;
    in_valid = 0; range_mm = 0; end_of_scan = 0;
    cfg_we = 0; cfg_idx = CFG_ANGLE_STEP; cfg_data = 0;
    send_idle_pct = 0; stall_pct = 0; hold_start = 0;
    step_q = 24'd11651; gain_q = 16'd4096;
    seen_cnt = 0; angle_q = 0; px = 0; py = 0; pux = 0; puy = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[i]) begin
      send(rows[i].range_mm, rows[i].end_of_scan);
      if (rows[i].typed) begin
        expected_q[expected_q.size() - 1].unflatness = rows[i].unflatness;
        expected_q[expected_q.size() - 1].scan_done = rows[i].scan_done;
      end
    end

    // receiver holds off while the sender keeps offering
    hold_start = 1;
    random_scans(300);

    write_reg(CFG_ANGLE_STEP, 24'd16777215);
    write_reg(CFG_GAIN, 24'd65535);
    send_idle_pct = 84;
    random_scans(150);

    write_reg(CFG_ANGLE_STEP, 24'd0);
    write_reg(CFG_GAIN, 24'd0);
    send_idle_pct = 0; stall_pct = 84;
    random_scans(150);

    write_reg(CFG_ANGLE_STEP, 24'($urandom));
    write_reg(CFG_GAIN, 24'($urandom_range(0, 65535)));
    send_idle_pct = 10; stall_pct = 10;
    random_scans(400);

    write_reg(CFG_ANGLE_STEP, 24'd11651);
    write_reg(CFG_GAIN, 24'd16384);
    send_idle_pct = 0; stall_pct = 0;
    random_scans(400);

    write_reg(CFG_ANGLE_STEP, 24'($urandom_range(1, 300000)));
    write_reg(CFG_GAIN, 24'd40000);
    send_idle_pct = 40; stall_pct = 40;
    random_scans(450);

    in_valid <= 0;
    wait (expected_q.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("scan_segment_unflatness_tb: PASS");
    else
      $display("scan_segment_unflatness_tb: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ssu_pkg.sv
rtl/ssu_ctrl.sv
rtl/ssu_dp.sv
rtl/scan_segment_unflatness.sv
test/scan_segment_unflatness_tb.sv
